[hdl/ess_pkg.sv]
// ess_pkg: types, character codes and helpers shared by the suffix stripper
// no dependencies
package ess_pkg;

  localparam int WIN_DEPTH   = 6;
  localparam int LEN_MAX_OUT = 63;

  typedef enum logic [1:0] {
    RULE_PLURAL = 2'd0,
    RULE_ING    = 2'd1,
    RULE_ED     = 2'd2
  } suffix_rule_t;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_Y = 8'h79;
  localparam logic [7:0] CH_Z = 8'h7a;

  typedef struct packed {
    logic [7:0] letter;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0] new_length;
    logic       stripped;
    logic [7:0] end_char1;
    logic [7:0] end_char0;
  } out_item_t;

  // window snapshot, most recent letter at index 0
  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] win;
  } snap_t;

  function automatic logic is_vowel(input logic [7:0] c);
    return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) ||
           (c == CH_U) || (c == CH_Y);
  endfunction

endpackage

[hdl/ess_window.sv]
// ess_window: running letter window and saturating count, word snapshot stage
// depends on ess_pkg
module ess_window import ess_pkg::*; #(
  parameter int MAX_WORD_LEN = 63,
  localparam int CW = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  in_item_t      in_item,
  input  logic          adv,
  output logic          snap_v,
  output snap_t         snap,
  output logic [CW-1:0] snap_cnt
);

  logic [WIN_DEPTH-1:0][7:0] win_r, win_nxt, win_sh;
  logic [CW-1:0]             cnt_r, cnt_nxt, cnt_inc;
  logic                      snap_v_r, snap_v_nxt;
  snap_t                     snap_r;
  logic [CW-1:0]             snap_cnt_r;
  logic                      load;

  assign win_sh  = {win_r[WIN_DEPTH-2:0], in_item.letter};
  assign cnt_inc = (cnt_r < CW'(MAX_WORD_LEN)) ? cnt_r + 1'b1 : cnt_r;
  assign load    = in_fire && in_item.word_end;

  always_comb begin
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    snap_v_nxt = snap_v_r;
    if (adv) begin
      snap_v_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_item.word_end) begin
        win_nxt    = '0;
        cnt_nxt    = '0;
        snap_v_nxt = 1'b1;
      end else begin
        win_nxt = win_sh;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      cnt_r    <= '0;
      snap_v_r <= 1'b0;
    end else begin
      win_r    <= win_nxt;
      cnt_r    <= cnt_nxt;
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r.win <= win_sh;
      snap_cnt_r <= cnt_inc;
    end
  end

  assign snap_v   = snap_v_r;
  assign snap     = snap_r;
  assign snap_cnt = snap_cnt_r;

endmodule

[hdl/ess_rule.sv]
// ess_rule: suffix rule evaluation on one word snapshot
// depends on ess_pkg
module ess_rule import ess_pkg::*; #(
  parameter int MAX_WORD_LEN = 63,
  localparam int CW = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic [1:0]    rule,
  input  snap_t         snap,
  input  logic [CW-1:0] cnt,
  output out_item_t     res
);

  logic [7:0]    b1, b2, b3, b4, b5, b6;
  logic [CW-1:0] len;
  logic [CW+5:0] len_ext;
  logic [7:0]    e1, e0;
  logic          ok;

  assign b1 = snap.win[0];
  assign b2 = snap.win[1];
  assign b3 = snap.win[2];
  assign b4 = snap.win[3];
  assign b5 = snap.win[4];
  assign b6 = snap.win[5];

  always_comb begin
    len = cnt;
    e1  = b2;
    e0  = b1;
    ok  = 1'b0;
    case (rule)
      RULE_PLURAL: begin
        if (cnt >= CW'(3) && b1 == CH_S) begin
          if (cnt >= CW'(4) && b2 == CH_E) begin
            if (b3 == CH_I) begin
              ok = 1'b1; len = cnt - CW'(2); e1 = b4; e0 = CH_Y;
            end else if (b3 == CH_H || b3 == CH_O ||
                         ((b3 == CH_S || b3 == CH_X || b3 == CH_Z) && cnt >= CW'(5))) begin
              ok = 1'b1; len = cnt - CW'(2); e1 = b4; e0 = b3;
            end
          end else if (b2 != CH_S) begin
            ok = 1'b1;
            if (!is_vowel(b2)) begin
              len = cnt - CW'(1); e1 = b3; e0 = b2;
            end
          end
        end
      end
      RULE_ING: begin
        if (cnt >= CW'(5) && b3 == CH_I && b2 == CH_N && b1 == CH_G) begin
          ok = 1'b1;
          if (b4 == CH_Y && !is_vowel(b5)) begin
            len = cnt - CW'(2); e1 = CH_I; e0 = CH_E;
          end else if (cnt >= CW'(7) && b4 == b5 && !is_vowel(b4)) begin
            len = cnt - CW'(4); e1 = b6; e0 = b5;
          end else begin
            len = cnt - CW'(3); e1 = b5; e0 = b4;
          end
        end
      end
      RULE_ED: begin
        if (cnt >= CW'(4) && b2 == CH_E && b1 == CH_D) begin
          ok = 1'b1;
          if (b3 == CH_E) begin
            len = cnt - CW'(1); e1 = CH_E; e0 = CH_E;
          end else if (b3 == CH_I && !is_vowel(b4)) begin
            len = cnt - CW'(2); e1 = b4; e0 = CH_Y;
          end else if (cnt >= CW'(6) && b3 == b4 && !is_vowel(b3)) begin
            len = cnt - CW'(3); e1 = b5; e0 = b4;
          end else if (cnt >= CW'(6) && !is_vowel(b3) && is_vowel(b4)) begin
            len = cnt - CW'(1); e1 = b3; e0 = CH_E;
          end else begin
            len = cnt - CW'(2); e1 = b4; e0 = b3;
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (len < CW'(2)) begin
      e1 = 8'h00;
    end
  end

  assign len_ext = {6'b0, len};

  always_comb begin
    res.stripped  = ok;
    res.end_char1 = e1;
    res.end_char0 = e0;
    if (len_ext > (CW+6)'(LEN_MAX_OUT)) begin
      res.new_length = 6'(LEN_MAX_OUT);
    end else begin
      res.new_length = len_ext[5:0];
    end
  end

endmodule

[hdl/english_suffix_stripper_top.sv]
// english_suffix_stripper_top: letter stream in, one stripped-word summary per word out
// result path: snapshot register, then output register once out_ready lets it advance
// throughput: one letter per cycle, limited only by out_ready back-pressure
// reset (synchronous, rst_n low): window and count cleared, rule set to plural, no result pending
// depends on ess_pkg, ess_window, ess_rule
module english_suffix_stripper_top import ess_pkg::*; #(
  parameter int MAX_WORD_LEN = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_WORD_LEN + 1);

  logic [1:0]    rule_r;
  logic          snap_v;
  snap_t         snap;
  logic [CW-1:0] snap_cnt;
  out_item_t     res;
  logic          out_v_r, out_v_nxt;
  out_item_t     out_r;
  logic          adv, in_fire;

  assign adv     = !out_v_r || out_ready;
  assign in_ready = !snap_v || adv;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= RULE_PLURAL;
    end else if (cfg_wr_en) begin
      rule_r <= cfg_wr_data;
    end
  end

  ess_window #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .adv      (adv),
    .snap_v   (snap_v),
    .snap     (snap),
    .snap_cnt (snap_cnt)
  );

  ess_rule #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_rule (
    .rule (rule_r),
    .snap (snap),
    .cnt  (snap_cnt),
    .res  (res)
  );

  assign out_v_nxt = adv ? snap_v : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && snap_v) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // a pending snapshot always holds at least one letter and never exceeds the limit
  a_snap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v |-> (snap_cnt != '0 && snap_cnt <= CW'(MAX_WORD_LEN)))
    else $error("snapshot count out of range");

  // a stalled snapshot keeps its contents
  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_v && !adv) |=> (snap_v && $stable(snap) && $stable(snap_cnt)))
    else $error("snapshot changed while stalled");

  // every result describes a word of at least one letter
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.new_length != 6'd0))
    else $error("result with zero length");

endmodule

[test/english_suffix_stripper_checker.sv]
`timescale 1ns / 1ps
// english_suffix_stripper_checker: watches the letter and summary channels, predicts each
// word summary from its own window, count and rule copy, and compares field by field
// depends on ess_pkg
module english_suffix_stripper_checker import ess_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  localparam int WORD_LEN_CAP = 63;
  localparam int REPORT_MAX   = 10;

  typedef logic [WIN_DEPTH-1:0][7:0] tail_t;

  tail_t      tail;
  int         letters_held;
  logic [1:0] active_rule;
  out_item_t  predicted_summaries[$];

  function automatic logic vowel_ch(input logic [7:0] c);
    return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) ||
           (c == CH_U) || (c == CH_Y);
  endfunction

  function automatic out_item_t strip_suffix(input tail_t t, input int n,
                                             input logic [1:0] rule);
    logic [7:0] b1, b2, b3, b4, b5, b6;
    logic [7:0] e1, e0;
    int         len;
    logic       ok;
    out_item_t  r;
    b1 = t[0];
    b2 = t[1];
    b3 = t[2];
    b4 = t[3];
    b5 = t[4];
    b6 = t[5];
    len = n;
    e1 = b2;
    e0 = b1;
    ok = 1'b0;
    if (rule == RULE_PLURAL) begin
      if (n >= 3 && b1 == CH_S) begin
        if (n >= 4 && b2 == CH_E) begin
          if (b3 == CH_I) begin
            ok = 1'b1; len = n - 2; e1 = b4; e0 = CH_Y;
          end else if (b3 == CH_H || b3 == CH_O ||
                       ((b3 == CH_S || b3 == CH_X || b3 == CH_Z) && n >= 5)) begin
            ok = 1'b1; len = n - 2; e1 = b4; e0 = b3;
          end
        end else if (b2 != CH_S) begin
          ok = 1'b1;
          if (!vowel_ch(b2)) begin
            len = n - 1; e1 = b3; e0 = b2;
          end
        end
      end
    end else if (rule == RULE_ING) begin
      if (n >= 5 && b3 == CH_I && b2 == CH_N && b1 == CH_G) begin
        ok = 1'b1;
        if (b4 == CH_Y && !vowel_ch(b5)) begin
          len = n - 2; e1 = CH_I; e0 = CH_E;
        end else if (n >= 7 && b4 == b5 && !vowel_ch(b4)) begin
          len = n - 4; e1 = b6; e0 = b5;
        end else begin
          len = n - 3; e1 = b5; e0 = b4;
        end
      end
    end else if (rule == RULE_ED) begin
      if (n >= 4 && b2 == CH_E && b1 == CH_D) begin
        ok = 1'b1;
        if (b3 == CH_E) begin
          len = n - 1; e1 = CH_E; e0 = CH_E;
        end else if (b3 == CH_I && !vowel_ch(b4)) begin
          len = n - 2; e1 = b4; e0 = CH_Y;
        end else if (n >= 6 && b3 == b4 && !vowel_ch(b3)) begin
          len = n - 3; e1 = b5; e0 = b4;
        end else if (n >= 6 && !vowel_ch(b3) && vowel_ch(b4)) begin
          len = n - 1; e1 = b3; e0 = CH_E;
        end else begin
          len = n - 2; e1 = b4; e0 = b3;
        end
      end
    end
    if (len < 2) e1 = 8'h00;
    if (len > LEN_MAX_OUT) len = LEN_MAX_OUT;
    r.new_length = len[5:0];
    r.stripped   = ok;
    r.end_char1  = e1;
    r.end_char0  = e0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    tail_t     shifted;
    int        n;
    if (!rst_n) begin
      tail = '0;
      letters_held = 0;
      active_rule = RULE_PLURAL;
      predicted_summaries.delete();
      fail_count = 0;
      pending = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_summaries.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("unexpected summary at %0t: len %0d strip %0b c1 %02h c0 %02h",
                     $realtime, out_data.new_length, out_data.stripped,
                     out_data.end_char1, out_data.end_char0);
          fail_count++;
        end else begin
          want = predicted_summaries.pop_front();
          checked++;
          if (out_data.new_length !== want.new_length || out_data.stripped !== want.stripped ||
              out_data.end_char1 !== want.end_char1 || out_data.end_char0 !== want.end_char0) begin
            if (fail_count < REPORT_MAX)
              $display("mismatch at %0t: expected len %0d strip %0b c1 %02h c0 %02h, got len %0d strip %0b c1 %02h c0 %02h",
                       $realtime, want.new_length, want.stripped, want.end_char1,
                       want.end_char0, out_data.new_length, out_data.stripped,
                       out_data.end_char1, out_data.end_char0);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) active_rule = cfg_wr_data;
      if (in_valid && in_ready) begin
        shifted = {tail[WIN_DEPTH-2:0], in_data.letter};
        n = (letters_held < WORD_LEN_CAP) ? letters_held + 1 : letters_held;
        if (in_data.word_end) begin
          predicted_summaries.push_back(strip_suffix(shifted, n, active_rule));
          tail = '0;
          letters_held = 0;
        end else begin
          tail = shifted;
          letters_held = n;
        end
      end
      pending = predicted_summaries.size();
    end
  end

endmodule

[test/english_suffix_stripper_top_tb.sv]
`timescale 1ns / 1ps
// english_suffix_stripper_top_tb: drives directed and random words through the suffix
// stripper under every rule code with random idling and a long output hold
// depends on ess_pkg, english_suffix_stripper_top and english_suffix_stripper_checker
module english_suffix_stripper_top_tb;
  import ess_pkg::*;

  localparam logic [1:0] RULE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LETTER_TARGET = 1650;
  localparam int PHASE_LETTERS = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_cnt;
  int letters_sent;
  int words_sent;
  logic idle_en;
  logic hold_req;

  logic [7:0] word_buf[$];

  string plural_tails[13] = '{"s", "es", "ies", "hes", "oes", "ses", "xes", "zes", "ss",
                              "as", "ys", "ts", "is"};
  string ing_tails[6]     = '{"ing", "ying", "ing", "ng", "eing", "ling"};
  string ed_tails[7]      = '{"ed", "eed", "ied", "d", "ted", "ued", "aded"};
  string vowels           = "aeiouy";
  string consonants       = "bcdfghjklmnpqrstvwxz";

  english_suffix_stripper_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  english_suffix_stripper_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d summaries outstanding", cycle_cnt, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver side, long hold counted here
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= idle_en ? ($urandom_range(0, 99) >= 12) : 1'b1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic push_letter(input logic [7:0] ch, input logic fin);
    if (idle_en && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{letter: ch, word_end: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    letters_sent++;
    @(negedge clk);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++)
      push_letter(word_buf[i], i == word_buf.size() - 1);
    words_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    word_buf.delete();
    add_text(s);
    send_word();
  endtask

  task automatic build_word(input logic [1:0] rule);
    int         pick;
    int         stem;
    logic [1:0] tail_rule;
    logic [7:0] c;
    word_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) stem = $urandom_range(0, 3);
    else if (pick < 90) stem = $urandom_range(4, 8);
    else if (pick < 99) stem = $urandom_range(9, 20);
    else stem = $urandom_range(56, 76);
    if ($urandom_range(0, 99) < 12) begin
      repeat (stem + 1) word_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (stem) begin
        if ($urandom_range(0, 99) < 35) word_buf.push_back(vowels[$urandom_range(0, 5)]);
        else word_buf.push_back(consonants[$urandom_range(0, 19)]);
      end
      if ($urandom_range(0, 99) < 30) begin
        c = consonants[$urandom_range(0, 19)];
        word_buf.push_back(c);
        word_buf.push_back(c);
      end
      if (rule == RULE_UNUSED || $urandom_range(0, 99) >= 80)
        tail_rule = 2'($urandom_range(0, 2));
      else
        tail_rule = rule;
      case (tail_rule)
        RULE_PLURAL: add_text(plural_tails[$urandom_range(0, 12)]);
        RULE_ING:    add_text(ing_tails[$urandom_range(0, 5)]);
        default:     add_text(ed_tails[$urandom_range(0, 6)]);
      endcase
    end
  endtask

  // sender pauses until every summary is back, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_rule(input logic [1:0] rule);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rule;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_start;
    logic [1:0] rule;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = RULE_PLURAL;
    in_valid = 1'b0;
    in_data = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    letters_sent = 0;
    words_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // plural rule straight out of reset
    word_buf = '{CH_A};
    send_word();
    word_buf = '{8'hff, 8'h00, CH_S};
    send_word();
    send_text("boxes");
    send_text("axes");
    send_text("cities");
    send_text("goes");
    send_text("bus");
    send_text("miss");
    set_rule(RULE_ING);
    send_text("tying");
    send_text("running");
    send_text("going");
    send_text("ring");
    set_rule(RULE_ED);
    send_text("agreed");
    send_text("cried");
    send_text("stopped");
    send_text("planed");
    send_text("hoped");
    send_text("ed");
    set_rule(RULE_UNUSED);
    send_text("cats");
    set_rule(RULE_PLURAL);

    phase = 0;
    while (letters_sent < LETTER_TARGET) begin
      rule = 2'($urandom_range(0, 3));
      set_rule(rule);
      idle_en = (phase != 3);
      if (phase == 5) hold_req = 1'b1;
      phase_start = letters_sent;
      while (letters_sent - phase_start < PHASE_LETTERS) begin
        build_word(rule);
        send_word();
      end
      phase++;
    end
    idle_en = 1'b1;
    drain();

    $display("run covered %0d words over %0d letters in %0d random phases", words_sent,
             letters_sent, phase);
    $display("%0d summaries checked under all rule codes, with idling and a long output hold",
             checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
